/* rtl/core/lcgr_pkg.sv */
// ============================================================================
// lcgr_pkg
// Shared constants for the range-shaped LCG random word generator.
// ============================================================================
package lcgr_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned HALF_W   = WORD_W / 2;
    localparam int unsigned S_DATA_W = 104;
    localparam int unsigned CNT_W    = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] LCG_MUL    = 32'd214013;
    localparam logic [WORD_W-1:0] LCG_ADD    = 32'd2531011;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'd1;

    localparam logic [WORD_W-1:0] MASK_ALL   = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] MASK_BYTE  = 32'h0000_00FF;
    localparam logic [WORD_W-1:0] MASK_SHORT = 32'h0000_FFFF;
    localparam logic [WORD_W-1:0] MASK_COLOR = 32'h00FF_FFFF;

    localparam logic [FUNC_W-1:0] FUNC_RAW   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_BELOW = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RANGE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_BYTE  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SHORT = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_COLOR = 3'd5;

    localparam logic [0:0] REG_SEED = 1'b0;

endpackage

/* rtl/core/lcgr_gen.sv */
// ============================================================================
// lcgr_gen
// Generator state: one LCG step per advance, seed reload, raw word assembly.
// ============================================================================
module lcgr_gen
    import lcgr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic [WORD_W-1:0] seed,
    input  logic              advance,
    output logic [WORD_W-1:0] raw
);

    logic [WORD_W-1:0] state_reg, state_next;
    logic [HALF_W-1:0] hi_prev_reg;
    logic [WORD_W-1:0] prod;

    assign prod = state_reg * LCG_MUL;

    always_comb begin
        state_next = state_reg;
        if (load) begin
            state_next = seed;
        end else if (advance) begin
            state_next = prod + LCG_ADD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEED_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hi_prev_reg <= state_reg[WORD_W-1:HALF_W];
        end
    end

    assign raw = {hi_prev_reg, state_reg[WORD_W-1:HALF_W]};

endmodule

/* rtl/core/lcgr_mod.sv */
// ============================================================================
// lcgr_mod
// Bit-serial restoring remainder: one dividend bit per cycle.
// ============================================================================
module lcgr_mod
    import lcgr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [WORD_W-1:0] rem
);

    logic              busy_reg, done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] dvd_reg, dvr_reg, rem_reg;
    logic [WORD_W:0]   shifted, rem_step;

    always_comb begin
        shifted  = {rem_reg, dvd_reg[WORD_W-1]};
        rem_step = shifted;
        if (shifted >= {1'b0, dvr_reg}) begin
            rem_step = shifted - {1'b0, dvr_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WORD_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            rem_reg <= rem_step[WORD_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/core/lcg_random_with_range_core.sv */
// ============================================================================
// lcg_random_with_range_core
// Random word generator with raw, bounded, range, byte, short and color modes.
// ============================================================================
// Requests arrive on the s_ stream: func, limit, range_low, range_high packed
// in s_tdata. Each request yields one 32-bit word on the m_ stream.
// A draw advances the 32-bit LCG twice and joins the two upper halves.
// From the accepting edge a request moves to decode; requests that take a
// draw then pass the two draw states and shape, and those that need a
// remainder the divide state, run by the bit-serial remainder unit, which
// retires one dividend bit per cycle. All end in the finish state.
// One request is in work at a time; s_tready is high only while idle, so a
// new request is taken only after the previous one leaves finish. A finished
// word sits in the output register so the next request is taken while it
// waits. If the receiver stalls, the output register holds and the
// following result waits in its final state until the register frees.
// The APB seed register answers at addresses 0 to 3; writing it reloads the
// generator state at once. Reset (aresetn low, synchronous) sets seed and
// state to one and empties the output register.
// ============================================================================
module lcg_random_with_range_core
    import lcgr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // [2:0] func, [34:3] limit, [66:35] range_low, [98:67] range_high
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [31:0] value
    output logic [WORD_W-1:0]   m_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [WORD_W-1:0]   pwdata,
    output logic [WORD_W-1:0]   prdata,
    output logic                pready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_DRAW1  = 3'd2;
    localparam logic [2:0] ST_DRAW2  = 3'd3;
    localparam logic [2:0] ST_SHAPE  = 3'd4;
    localparam logic [2:0] ST_DIVIDE = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [WORD_W-1:0] seed_reg;
    logic              seed_wr;

    logic [FUNC_W-1:0] func_reg;
    logic [WORD_W-1:0] limit_reg, lo_reg, hi_reg;
    logic [WORD_W-1:0] mask_reg, off_reg, dvr_reg, res_reg;
    logic              mod_reg;
    logic [WORD_W-1:0] out_reg;
    logic              out_vld_reg;

    logic              accept, advance, div_start, div_busy, div_done, out_load;
    logic [WORD_W-1:0] raw, raw_masked, rem;
    logic              lo_gt;
    logic [WORD_W-1:0] lo_s, hi_s, span;
    logic [HALF_W-1:0] n16;

    logic              skip;
    logic [WORD_W-1:0] skip_val, mask_d, off_d, dvr_d;
    logic              mod_d;

    assign pready  = 1'b1;
    assign prdata  = seed_reg;
    assign seed_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SEED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
        end else if (seed_wr) begin
            seed_reg <= pwdata;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign advance  = (state_reg == ST_DRAW1) || (state_reg == ST_DRAW2);
    assign out_load = (state_reg == ST_FINISH) && (!out_vld_reg || m_tready);

    lcgr_gen u_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (seed_wr),
        .seed    (pwdata),
        .advance (advance),
        .raw     (raw)
    );

    assign raw_masked = raw & mask_reg;
    assign div_start  = (state_reg == ST_SHAPE) && mod_reg;

    lcgr_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (raw_masked),
        .divisor  (dvr_reg),
        .busy     (div_busy),
        .done     (div_done),
        .rem      (rem)
    );

    always_comb begin
        lo_gt = $signed(lo_reg) > $signed(hi_reg);
        lo_s  = lo_gt ? hi_reg : lo_reg;
        hi_s  = lo_gt ? lo_reg : hi_reg;
        span  = hi_s - lo_s + 1'b1;
        n16   = limit_reg[HALF_W-1:0];

        skip     = 1'b0;
        skip_val = '0;
        mask_d   = MASK_ALL;
        off_d    = '0;
        dvr_d    = limit_reg;
        mod_d    = 1'b0;
        case (func_reg)
            FUNC_RAW: begin
                mask_d = MASK_ALL;
            end
            FUNC_BELOW: begin
                skip  = (limit_reg == '0);
                mod_d = 1'b1;
            end
            FUNC_RANGE: begin
                skip     = (lo_reg == hi_reg);
                skip_val = lo_reg;
                off_d    = lo_s;
                dvr_d    = span;
                mod_d    = (span != '0);
            end
            FUNC_BYTE: begin
                mask_d = MASK_BYTE;
            end
            FUNC_SHORT: begin
                skip   = (n16 == '0);
                mask_d = MASK_SHORT;
                dvr_d  = {{(WORD_W-HALF_W){1'b0}}, n16};
                mod_d  = 1'b1;
            end
            FUNC_COLOR: begin
                mask_d = MASK_COLOR;
            end
            default: begin
                skip = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = skip ? ST_FINISH : ST_DRAW1;
            end
            ST_DRAW1: begin
                state_next = ST_DRAW2;
            end
            ST_DRAW2: begin
                state_next = ST_SHAPE;
            end
            ST_SHAPE: begin
                state_next = mod_reg ? ST_DIVIDE : ST_FINISH;
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg  <= s_tdata[FUNC_W-1:0];
            limit_reg <= s_tdata[FUNC_W +: WORD_W];
            lo_reg    <= s_tdata[FUNC_W+WORD_W +: WORD_W];
            hi_reg    <= s_tdata[FUNC_W+2*WORD_W +: WORD_W];
        end
        if (state_reg == ST_DECODE) begin
            mask_reg <= mask_d;
            off_reg  <= off_d;
            dvr_reg  <= dvr_d;
            mod_reg  <= mod_d;
            res_reg  <= skip_val;
        end
        if ((state_reg == ST_SHAPE) && !mod_reg) begin
            res_reg <= raw_masked + off_reg;
        end
        if ((state_reg == ST_DIVIDE) && div_done) begin
            res_reg <= rem + off_reg;
        end
        if (out_load) begin
            out_reg <= res_reg;
        end
    end

    assign m_tdata  = out_reg;
    assign m_tvalid = out_vld_reg;

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    a_div_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> state_reg == ST_DIVIDE)
        else $error("remainder unit busy outside divide state");

    a_finish_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && s_tready)
        else $error("finished result not presented");
`endif

endmodule
